// ----- sv/su2_spin_three_halves_rep_macros.svh -----
// assertion macros for the checker file
`ifndef SU2_SPIN_THREE_HALVES_REP_MACROS_SVH
`define SU2_SPIN_THREE_HALVES_REP_MACROS_SVH

// clocked check, off while reset is asserted
`define SU2_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("su2s3h check failed");

// clocked check that also runs during reset
`define SU2_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("su2s3h check failed");

`endif

// ----- sv/su2s3h_pkg.sv -----
// constants and operand tables for the spin-3/2 representation block
`default_nettype none
package su2s3h_pkg;

  localparam int IN_W   = 18;
  localparam int U_W    = 19;
  localparam int OUT_W  = 19;
  localparam int CL_W   = 21;
  localparam int K_W    = 26;
  localparam int ROOT3_FRAC = 24;
  localparam logic signed [K_W-1:0] ROOT3_Q24 = 26'sd29058991;

  localparam logic [1:0] FIRST_ROW = 2'd0;
  localparam logic [1:0] LAST_ROW  = 2'd3;

  typedef logic [1:0] usel_t;
  localparam usel_t U00 = 2'd0;
  localparam usel_t U01 = 2'd1;
  localparam usel_t U10 = 2'd2;
  localparam usel_t U11 = 2'd3;

  // [row][col]: linear factor, squared element, triple-product factors
  localparam usel_t X_SEL [4][4] = '{
    '{U00, U01, U00, U01}, '{U10, U11, U10, U11},
    '{U00, U01, U00, U01}, '{U10, U11, U10, U11}};
  localparam usel_t Y_SEL [4][4] = '{
    '{U00, U00, U01, U01}, '{U00, U00, U01, U01},
    '{U10, U10, U11, U11}, '{U10, U10, U11, U11}};
  localparam usel_t V_SEL [4][4] = '{
    '{U00, U00, U00, U00}, '{U00, U10, U11, U00},
    '{U00, U11, U10, U00}, '{U00, U00, U00, U00}};
  localparam usel_t W_SEL [4][4] = '{
    '{U00, U00, U00, U00}, '{U00, U00, U00, U00},
    '{U00, U00, U11, U00}, '{U00, U00, U00, U00}};
  localparam usel_t P_SEL [4][4] = '{
    '{U00, U00, U00, U00}, '{U00, U01, U01, U00},
    '{U00, U10, U01, U00}, '{U00, U00, U00, U00}};

  // bit c set: column c of that row
  localparam logic [3:0] SCALE_MASK [4] = '{4'b0110, 4'b1001, 4'b1001, 4'b0110};
  localparam logic [3:0] EXTRA_MASK [4] = '{4'b0000, 4'b0110, 4'b0110, 4'b0000};

endpackage
`default_nettype wire

// ----- sv/su2_spin_three_halves_rep.sv -----
// Spin-3/2 representation of an SU(2) element. Each accepted word (a, b) gives
// four result words, rows 0 to 3 of the 4x4 complex matrix, on consecutive
// cycles when the output is not stalled; a new input word is taken in the same
// cycle as the last row of the previous one leaves the row sequencer. Rows are
// read from the registered input word and pass through four register stages
// (square and pair products, cubes and triple products, sqrt(3) scaling,
// rounding and saturation). The whole pipeline holds while the output word is
// stalled.
`default_nettype none
module su2_spin_three_halves_rep import su2s3h_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  wire  logic                    clk_i,
  input  wire  logic                    rst_ni,
  input  wire  logic                    in_valid_i,
  output logic                          in_stall_o,
  input  wire  logic signed [IN_W-1:0]  a_re_i,
  input  wire  logic signed [IN_W-1:0]  a_im_i,
  input  wire  logic signed [IN_W-1:0]  b_re_i,
  input  wire  logic signed [IN_W-1:0]  b_im_i,
  output logic                          out_valid_o,
  input  wire  logic                    out_stall_i,
  output logic [1:0]                    row_index_o,
  output logic                          last_row_o,
  output logic signed [OUT_W-1:0]       col0_re_o,
  output logic signed [OUT_W-1:0]       col0_im_o,
  output logic signed [OUT_W-1:0]       col1_re_o,
  output logic signed [OUT_W-1:0]       col1_im_o,
  output logic signed [OUT_W-1:0]       col2_re_o,
  output logic signed [OUT_W-1:0]       col2_im_o,
  output logic signed [OUT_W-1:0]       col3_re_o,
  output logic signed [OUT_W-1:0]       col3_im_o
);

  localparam int SQ_W   = 40 - FRAC_BITS;
  localparam int P1_W   = 2 * U_W + 1;
  localparam int P2_W   = SQ_W + U_W + 1;
  localparam int CU_RAW = P2_W - FRAC_BITS + 1;
  localparam int CU_W   = (CU_RAW > 8) ? CU_RAW : 8;
  localparam int SUM_W  = (CU_W + 2 > CL_W + 1) ? CU_W + 2 : CL_W + 1;
  localparam int PR_W   = CL_W + K_W;
  localparam int SAT_W  = (SUM_W > PR_W) ? SUM_W : PR_W;

  localparam logic signed [P1_W-1:0]  HALF1 = P1_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0]  HALF2 = P2_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PR_W-1:0]  HALF3 = PR_W'(1) <<< (ROOT3_FRAC - 1);
  localparam logic signed [SUM_W-1:0] CL_HI = SUM_W'((1 << (CL_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] CL_LO = SUM_W'(-(1 << (CL_W - 1)));
  localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((1 << (OUT_W - 1)) - 1);
  localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(-(1 << (OUT_W - 1)));

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI)      r = SAT_HI[OUT_W-1:0];
    else if (v < SAT_LO) r = SAT_LO[OUT_W-1:0];
    else                 r = v[OUT_W-1:0];
    return r;
  endfunction

  logic adv;
  logic out_valid_q;
  assign adv = !out_valid_q || !out_stall_i;

  // ---------------- row sequencer
  logic                   hv_q;
  logic [1:0]             cnt_q;
  logic signed [IN_W-1:0] a_re_q, a_im_q, b_re_q, b_im_q;
  logic take, emit;

  assign emit       = adv && hv_q;
  assign in_stall_o = hv_q && !(adv && cnt_q == LAST_ROW);
  assign take       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      cnt_q <= FIRST_ROW;
    end else begin
      if (emit) begin
        if (cnt_q == LAST_ROW) begin
          hv_q  <= 1'b0;
          cnt_q <= FIRST_ROW;
        end else begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      if (take) begin
        hv_q  <= 1'b1;
        cnt_q <= FIRST_ROW;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_re_q <= a_re_i;
      a_im_q <= a_im_i;
      b_re_q <= b_re_i;
      b_im_q <= b_im_i;
    end
  end

  // second row is (-conj(b), conj(a))
  logic signed [U_W-1:0] u_re [4];
  logic signed [U_W-1:0] u_im [4];
  always_comb begin
    u_re[U00] = U_W'(a_re_q);
    u_im[U00] = U_W'(a_im_q);
    u_re[U01] = U_W'(b_re_q);
    u_im[U01] = U_W'(b_im_q);
    u_re[U10] = -U_W'(b_re_q);
    u_im[U10] = U_W'(b_im_q);
    u_re[U11] = U_W'(a_re_q);
    u_im[U11] = -U_W'(a_im_q);
  end

  // ---------------- stage 1: squares and pair products
  logic                   s1_v_q;
  logic [1:0]             s1_row_q;
  logic signed [SQ_W-1:0] s1_sq_re_q [4], s1_sq_im_q [4];
  logic signed [SQ_W-1:0] s1_pr_re_q [4], s1_pr_im_q [4];
  logic signed [U_W-1:0]  s1_x_re_q [4], s1_x_im_q [4];
  logic signed [U_W-1:0]  s1_p_re_q [4], s1_p_im_q [4];
  logic signed [SQ_W-1:0] s1_sq_re_d [4], s1_sq_im_d [4];
  logic signed [SQ_W-1:0] s1_pr_re_d [4], s1_pr_im_d [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [P1_W-1:0] yr, yi, vr, vi, wr, wi, t_re, t_im, r_re, r_im;
      yr = P1_W'(u_re[Y_SEL[cnt_q][c]]);
      yi = P1_W'(u_im[Y_SEL[cnt_q][c]]);
      vr = P1_W'(u_re[V_SEL[cnt_q][c]]);
      vi = P1_W'(u_im[V_SEL[cnt_q][c]]);
      wr = P1_W'(u_re[W_SEL[cnt_q][c]]);
      wi = P1_W'(u_im[W_SEL[cnt_q][c]]);
      t_re = yr * yr - yi * yi;
      t_im = yr * yi + yi * yr;
      r_re = vr * wr - vi * wi;
      r_im = vr * wi + vi * wr;
      s1_sq_re_d[c] = SQ_W'((t_re + HALF1) >>> FRAC_BITS);
      s1_sq_im_d[c] = SQ_W'((t_im + HALF1) >>> FRAC_BITS);
      s1_pr_re_d[c] = SQ_W'((r_re + HALF1) >>> FRAC_BITS);
      s1_pr_im_d[c] = SQ_W'((r_im + HALF1) >>> FRAC_BITS);
    end
  end

  // ---------------- stage 2: cubes and triple products
  logic                    s2_v_q;
  logic [1:0]              s2_row_q;
  logic signed [SUM_W-1:0] s2_val_re_q [4], s2_val_im_q [4];
  logic signed [SUM_W-1:0] s2_val_re_d [4], s2_val_im_d [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [P2_W-1:0] xr, xi, qr, qi, pr, pi, er, ei, m_re, m_im, e_re, e_im;
      logic signed [CU_W-1:0] mr, mi, tr, ti;
      xr = P2_W'(s1_x_re_q[c]);
      xi = P2_W'(s1_x_im_q[c]);
      qr = P2_W'(s1_sq_re_q[c]);
      qi = P2_W'(s1_sq_im_q[c]);
      pr = P2_W'(s1_p_re_q[c]);
      pi = P2_W'(s1_p_im_q[c]);
      er = P2_W'(s1_pr_re_q[c]);
      ei = P2_W'(s1_pr_im_q[c]);
      m_re = xr * qr - xi * qi;
      m_im = xr * qi + xi * qr;
      e_re = pr * er - pi * ei;
      e_im = pr * ei + pi * er;
      mr = CU_W'((m_re + HALF2) >>> FRAC_BITS);
      mi = CU_W'((m_im + HALF2) >>> FRAC_BITS);
      tr = CU_W'((e_re + HALF2) >>> FRAC_BITS);
      ti = CU_W'((e_im + HALF2) >>> FRAC_BITS);
      if (EXTRA_MASK[s1_row_q][c]) begin
        s2_val_re_d[c] = SUM_W'(mr) + (SUM_W'(tr) <<< 1);
        s2_val_im_d[c] = SUM_W'(mi) + (SUM_W'(ti) <<< 1);
      end else begin
        s2_val_re_d[c] = SUM_W'(mr);
        s2_val_im_d[c] = SUM_W'(mi);
      end
    end
  end

  // ---------------- stage 3: sqrt(3) scaling
  logic                    s3_v_q;
  logic [1:0]              s3_row_q;
  logic signed [SUM_W-1:0] s3_val_re_q [4], s3_val_im_q [4];
  logic signed [PR_W-1:0]  s3_pr_re_q [4], s3_pr_im_q [4];
  logic signed [PR_W-1:0]  s3_pr_re_d [4], s3_pr_im_d [4];

  // clamping first keeps the saturated outcome, since sqrt(3) > 1
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic signed [SUM_W-1:0] cr, ci;
      cr = (s2_val_re_q[c] > CL_HI) ? CL_HI :
           (s2_val_re_q[c] < CL_LO) ? CL_LO : s2_val_re_q[c];
      ci = (s2_val_im_q[c] > CL_HI) ? CL_HI :
           (s2_val_im_q[c] < CL_LO) ? CL_LO : s2_val_im_q[c];
      s3_pr_re_d[c] = PR_W'(signed'(cr[CL_W-1:0])) * PR_W'(ROOT3_Q24);
      s3_pr_im_d[c] = PR_W'(signed'(ci[CL_W-1:0])) * PR_W'(ROOT3_Q24);
    end
  end

  // ---------------- output stage: rounding and saturation
  logic [1:0]              row_q;
  logic signed [OUT_W-1:0] o_re_q [4], o_im_q [4];
  logic signed [OUT_W-1:0] o_re_d [4], o_im_d [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (SCALE_MASK[s3_row_q][c]) begin
        o_re_d[c] = sat_out(SAT_W'((s3_pr_re_q[c] + HALF3) >>> ROOT3_FRAC));
        o_im_d[c] = sat_out(SAT_W'((s3_pr_im_q[c] + HALF3) >>> ROOT3_FRAC));
      end else begin
        o_re_d[c] = sat_out(SAT_W'(s3_val_re_q[c]));
        o_im_d[c] = sat_out(SAT_W'(s3_val_im_q[c]));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= hv_q;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      out_valid_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_row_q <= cnt_q;
      s2_row_q <= s1_row_q;
      s3_row_q <= s2_row_q;
      row_q    <= s3_row_q;
      for (int c = 0; c < 4; c++) begin
        s1_sq_re_q[c]  <= s1_sq_re_d[c];
        s1_sq_im_q[c]  <= s1_sq_im_d[c];
        s1_pr_re_q[c]  <= s1_pr_re_d[c];
        s1_pr_im_q[c]  <= s1_pr_im_d[c];
        s1_x_re_q[c]   <= u_re[X_SEL[cnt_q][c]];
        s1_x_im_q[c]   <= u_im[X_SEL[cnt_q][c]];
        s1_p_re_q[c]   <= u_re[P_SEL[cnt_q][c]];
        s1_p_im_q[c]   <= u_im[P_SEL[cnt_q][c]];
        s2_val_re_q[c] <= s2_val_re_d[c];
        s2_val_im_q[c] <= s2_val_im_d[c];
        s3_val_re_q[c] <= s2_val_re_q[c];
        s3_val_im_q[c] <= s2_val_im_q[c];
        s3_pr_re_q[c]  <= s3_pr_re_d[c];
        s3_pr_im_q[c]  <= s3_pr_im_d[c];
        o_re_q[c]      <= o_re_d[c];
        o_im_q[c]      <= o_im_d[c];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign row_index_o = row_q;
  assign last_row_o  = (row_q == LAST_ROW);
  assign col0_re_o   = o_re_q[0];
  assign col0_im_o   = o_im_q[0];
  assign col1_re_o   = o_re_q[1];
  assign col1_im_o   = o_im_q[1];
  assign col2_re_o   = o_re_q[2];
  assign col2_im_o   = o_im_q[2];
  assign col3_re_o   = o_re_q[3];
  assign col3_im_o   = o_im_q[3];

endmodule
`default_nettype wire

// ----- sv/su2s3h_checker.sv -----
// port-level checks for the spin-3/2 representation block, with its bind
`default_nettype none
`include "su2_spin_three_halves_rep_macros.svh"
module su2s3h_checker import su2s3h_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_stall_o,
  input wire logic signed [IN_W-1:0]  a_re_i,
  input wire logic signed [IN_W-1:0]  a_im_i,
  input wire logic signed [IN_W-1:0]  b_re_i,
  input wire logic signed [IN_W-1:0]  b_im_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_stall_i,
  input wire logic [1:0]              row_index_o,
  input wire logic                    last_row_o,
  input wire logic signed [OUT_W-1:0] col0_re_o,
  input wire logic signed [OUT_W-1:0] col0_im_o,
  input wire logic signed [OUT_W-1:0] col1_re_o,
  input wire logic signed [OUT_W-1:0] col1_im_o,
  input wire logic signed [OUT_W-1:0] col2_re_o,
  input wire logic signed [OUT_W-1:0] col2_im_o,
  input wire logic signed [OUT_W-1:0] col3_re_o,
  input wire logic signed [OUT_W-1:0] col3_im_o
);

  logic [4*IN_W-1:0]      in_word;
  logic [3+8*OUT_W-1:0]   out_word;
  logic                   out_take;

  assign in_word  = {a_re_i, a_im_i, b_re_i, b_im_i};
  assign out_word = {row_index_o, last_row_o, col0_re_o, col0_im_o, col1_re_o, col1_im_o,
                     col2_re_o, col2_im_o, col3_re_o, col3_im_o};
  assign out_take = out_valid_o && !out_stall_i;

  // a stalled input word holds
  `SU2_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word))

  // a stalled result word holds
  `SU2_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word))

  // last flag marks row three only
  `SU2_ASSERT(a_last_row, out_valid_o |-> (last_row_o == (row_index_o == LAST_ROW)))

  // rows of one matrix leave back to back
  `SU2_ASSERT(a_row_seq, out_take && !last_row_o |=> out_valid_o && (row_index_o == $past(row_index_o) + 2'd1))

  // nothing comes out right after reset
  `SU2_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o)

endmodule

bind su2_spin_three_halves_rep su2s3h_checker u_su2s3h_checker (.*);
`default_nettype wire
